### rtl/packbits_row_encoder_macros.svh
// assertion macros shared by the packbits row encoder
`ifndef PACKBITS_ROW_ENCODER_MACROS_SVH
`define PACKBITS_ROW_ENCODER_MACROS_SVH

// condition implies consequence in the same cycle
`define PBRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the following cycle
`define PBRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pbre_pkg.sv
// shared types and constants of the packbits row encoder
package pbre_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // run control byte is 257 minus the run length, modulo 256
    localparam logic [BYTE_W:0] RUN_BASE = 9'd257;

    typedef enum logic {
        CMD_RUN,
        CMD_LIT
    } t_cmd_kind;

    // one command from the front part to the back part
    typedef struct packed {
        t_cmd_kind           kind;
        logic [BYTE_W-1:0]   ctrl;
        logic [BYTE_W-1:0]   value;
        logic [CNT_W-1:0]    count;
        logic                bank;
        logic                item_end;
        logic                row_end;
    } t_cmd;

    // literal bank handed back by the back part
    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

endpackage

### rtl/pbre_in_if.sv
// input byte channel of the packbits row encoder
interface pbre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       row_last;

    modport source (output valid, output data_byte, output row_last, input ready);
    modport sink (input valid, input data_byte, input row_last, output ready);
endinterface

### rtl/pbre_out_if.sv
// output stream channel of the packbits row encoder
interface pbre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_control;
    logic       last_of_item;
    logic       row_end;

    modport source (output valid, output out_byte, output is_control,
                    output last_of_item, output row_end, input ready);
    modport sink (input valid, input out_byte, input is_control,
                  input last_of_item, input row_end, output ready);
endinterface

### rtl/pbre_ram.sv
// generic simple dual port ram with registered read
module pbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pbre_cmd_queue.sv
// short command queue between the front and back parts
module pbre_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbre_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    output logic          o_pop_valid,
    output pbre_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop
);
    import pbre_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;
    assign o_full      = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_cmd   = r_slot[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

endmodule

### rtl/pbre_front.sv
// front part: takes row bytes, tracks runs and literals, issues commands
module pbre_front #(
    parameter int MAX_RUN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pbre_in_if.sink                       i_in,
    output logic                          o_push,
    output pbre_pkg::t_cmd                o_push_cmd,
    input  logic                          i_q_full,
    output logic                          o_we,
    output logic [$clog2(MAX_RUN):0]      o_waddr,
    output logic [7:0]                    o_wdata,
    input  pbre_pkg::t_bank_rel           i_rel
);
    import pbre_pkg::*;

    localparam int LW = $clog2(MAX_RUN + 1);
    localparam int IW = $clog2(MAX_RUN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_LAST
    } t_fstate;

    t_fstate           r_state, n_state;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_in_run, n_in_run;
    logic              r_have_prev, n_have_prev;
    logic [BYTE_W-1:0] r_prev, n_prev;
    logic [LW-1:0]     r_rl, n_rl;
    logic [LW-1:0]     r_lc, n_lc;
    logic              r_wbank, n_wbank;
    logic [1:0]        r_busy, n_busy;

    t_cmd              cmd;
    logic              have_cmd;
    logic              need_wr;
    logic              go;
    logic [1:0]        set_mask;
    logic [1:0]        rel_mask;
    logic [LW-1:0]     rl_inc;
    logic [LW-1:0]     lc_inc;

    function automatic logic [BYTE_W-1:0] run_ctrl(input logic [CNT_W-1:0] len);
        logic [BYTE_W:0] diff;
        diff = RUN_BASE - {1'b0, len};
        return diff[BYTE_W-1:0];
    endfunction

    assign rl_inc     = r_rl + LW'(1);
    assign lc_inc     = r_lc + LW'(1);
    assign i_in.ready = (r_state == S_IDLE);
    assign rel_mask   = i_rel.valid ? (2'b01 << i_rel.bank) : 2'b00;

    // classify the held byte and plan commands and store writes
    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_last      = r_last;
        n_in_run    = r_in_run;
        n_have_prev = r_have_prev;
        n_prev      = r_prev;
        n_rl        = r_rl;
        n_lc        = r_lc;
        n_wbank     = r_wbank;
        cmd         = '0;
        have_cmd    = 1'b0;
        need_wr     = 1'b0;
        set_mask    = 2'b00;
        go          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_byte  = i_in.data_byte;
                    n_last  = i_in.row_last;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                cmd.item_end = !r_last;
                if (!r_have_prev) begin
                    n_have_prev = 1'b1;
                    n_in_run    = 1'b0;
                    n_rl        = '0;
                end else if (r_byte == r_prev && r_in_run) begin
                    // run grows, split at the maximum length
                    if (rl_inc == LW'(MAX_RUN)) begin
                        have_cmd  = 1'b1;
                        cmd.kind  = CMD_RUN;
                        cmd.ctrl  = run_ctrl(CNT_W'(MAX_RUN));
                        cmd.value = r_prev;
                        n_rl      = '0;
                    end else begin
                        n_rl = rl_inc;
                    end
                end else if (r_byte == r_prev) begin
                    // run starts, pending literal goes out first
                    if (r_lc != '0) begin
                        have_cmd  = 1'b1;
                        cmd.kind  = CMD_LIT;
                        cmd.count = CNT_W'(r_lc);
                        cmd.ctrl  = CNT_W'(r_lc) - 8'd1;
                        cmd.bank  = r_wbank;
                        set_mask  = 2'b01 << r_wbank;
                        n_wbank   = !r_wbank;
                        n_lc      = '0;
                    end
                    n_rl     = LW'(1);
                    n_in_run = 1'b1;
                end else if (r_in_run) begin
                    // run ends
                    have_cmd  = 1'b1;
                    cmd.kind  = CMD_RUN;
                    cmd.ctrl  = run_ctrl(CNT_W'(rl_inc));
                    cmd.value = r_prev;
                    n_rl      = '0;
                    n_in_run  = 1'b0;
                end else begin
                    // previous byte joins the literal, full literal goes out
                    need_wr = 1'b1;
                    if (lc_inc == LW'(MAX_RUN)) begin
                        have_cmd  = 1'b1;
                        cmd.kind  = CMD_LIT;
                        cmd.count = CNT_W'(MAX_RUN);
                        cmd.ctrl  = CNT_W'(MAX_RUN) - 8'd1;
                        cmd.bank  = r_wbank;
                        set_mask  = 2'b01 << r_wbank;
                        n_wbank   = !r_wbank;
                        n_lc      = '0;
                    end else begin
                        n_lc = lc_inc;
                    end
                end
                n_prev  = r_byte;
                n_state = r_last ? S_LAST : S_IDLE;
            end
            S_LAST: begin
                // row end closes the open run or literal
                have_cmd     = 1'b1;
                cmd.item_end = 1'b1;
                cmd.row_end  = 1'b1;
                if (r_in_run) begin
                    cmd.kind  = CMD_RUN;
                    cmd.ctrl  = run_ctrl(CNT_W'(rl_inc));
                    cmd.value = r_prev;
                end else begin
                    need_wr   = 1'b1;
                    cmd.kind  = CMD_LIT;
                    cmd.count = CNT_W'(lc_inc);
                    cmd.ctrl  = CNT_W'(r_lc);
                    cmd.bank  = r_wbank;
                    set_mask  = 2'b01 << r_wbank;
                    n_wbank   = !r_wbank;
                end
                n_in_run    = 1'b0;
                n_have_prev = 1'b0;
                n_prev      = '0;
                n_rl        = '0;
                n_lc        = '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        go = (!have_cmd || !i_q_full) && (!need_wr || !r_busy[r_wbank]);

        // hold everything while the queue or the literal bank is not free
        if ((r_state == S_STEP || r_state == S_LAST) && !go) begin
            n_state     = r_state;
            n_in_run    = r_in_run;
            n_have_prev = r_have_prev;
            n_prev      = r_prev;
            n_rl        = r_rl;
            n_lc        = r_lc;
            n_wbank     = r_wbank;
            set_mask    = 2'b00;
        end

        n_busy = (r_busy & ~rel_mask) | set_mask;
    end

    assign o_push     = (r_state == S_STEP || r_state == S_LAST) && have_cmd && go;
    assign o_push_cmd = cmd;
    assign o_we       = (r_state == S_STEP || r_state == S_LAST) && need_wr && go;
    assign o_waddr    = {r_wbank, r_lc[IW-1:0]};
    assign o_wdata    = r_prev;

    // state and tracking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_run    <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_rl        <= '0;
            r_lc        <= '0;
            r_wbank     <= 1'b0;
            r_busy      <= 2'b00;
        end else begin
            r_state     <= n_state;
            r_in_run    <= n_in_run;
            r_have_prev <= n_have_prev;
            r_prev      <= n_prev;
            r_rl        <= n_rl;
            r_lc        <= n_lc;
            r_wbank     <= n_wbank;
            r_busy      <= n_busy;
        end
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

### rtl/pbre_back.sv
// back part: turns commands into output bytes, reads literal bytes from the store
module pbre_back #(
    parameter int MAX_RUN = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_pop_valid,
    input  pbre_pkg::t_cmd           i_pop_cmd,
    output logic                     o_pop,
    output logic [$clog2(MAX_RUN):0] o_raddr,
    input  logic [7:0]               i_rdata,
    output pbre_pkg::t_bank_rel      o_rel,
    pbre_out_if.source               o_out
);
    import pbre_pkg::*;

    localparam int IW = $clog2(MAX_RUN);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_LIT
    } t_bstate;

    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic              r_bank, n_bank;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_octl, n_octl;
    logic              r_oend, n_oend;
    logic              r_orow, n_orow;
    logic              slot_free;
    logic              lit_last;

    assign slot_free = !r_valid || o_out.ready;
    assign lit_last  = (CNT_W'(r_idx) == r_cmd.count - 8'd1);

    // byte sequencer feeding the output register
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_bank    = r_bank;
        n_idx     = r_idx;
        n_valid   = r_valid && !o_out.ready;
        n_obyte   = r_obyte;
        n_octl    = r_octl;
        n_oend    = r_oend;
        n_orow    = r_orow;
        o_pop     = 1'b0;
        o_rel     = '0;

        case (r_state)
            B_IDLE: begin
                if (i_pop_valid && slot_free) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_pop_cmd;
                    n_valid = 1'b1;
                    n_obyte = i_pop_cmd.ctrl;
                    n_octl  = 1'b1;
                    n_oend  = 1'b0;
                    n_orow  = 1'b0;
                    if (i_pop_cmd.kind == CMD_LIT) begin
                        n_bank  = i_pop_cmd.bank;
                        n_idx   = '0;
                        n_state = B_LIT;
                    end else begin
                        n_state = B_RUN;
                    end
                end
            end
            B_RUN: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_obyte = r_cmd.value;
                    n_octl  = 1'b0;
                    n_oend  = r_cmd.item_end;
                    n_orow  = r_cmd.row_end;
                    n_state = B_IDLE;
                end
            end
            B_LIT: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_obyte = i_rdata;
                    n_octl  = 1'b0;
                    if (lit_last) begin
                        n_oend      = r_cmd.item_end;
                        n_orow      = r_cmd.row_end;
                        o_rel.valid = 1'b1;
                        o_rel.bank  = r_bank;
                        n_state     = B_IDLE;
                    end else begin
                        n_oend = 1'b0;
                        n_orow = 1'b0;
                        n_idx  = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // read address is the next index, so the registered read returns the byte in use
    assign o_raddr = {n_bank, n_idx};

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_obyte;
    assign o_out.is_control   = r_octl;
    assign o_out.last_of_item = r_oend;
    assign o_out.row_end      = r_orow;

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_bank  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_bank  <= n_bank;
            r_idx   <= n_idx;
        end
        r_cmd   <= n_cmd;
        r_obyte <= n_obyte;
        r_octl  <= n_octl;
        r_oend  <= n_oend;
        r_orow  <= n_orow;
    end

endmodule

### rtl/packbits_row_encoder.sv
// top level of the packbits row encoder
//
// i_in carries the raw bytes of a raster row, row_last set on the final byte.
// o_out carries the packbits stream: control bytes flagged by is_control,
// last_of_item on the final byte caused by an input byte, row_end on the
// final byte of the row. Both channels move a request on valid and ready high.
// An input byte is held in the front part through S_STEP, a row's last byte also
// through S_LAST; the front holds off further bytes while the command queue is
// full or while the literal bank it must write is still being read out.
// While the receiver is ready the back part sends one byte per cycle: a run is
// 2 bytes, a literal its control byte and then one stored byte per cycle from
// the literal store ram. A command's first byte leaves via a queue slot and
// the output register. Literals are kept in two banks of MAX_RUN bytes so one
// can fill while the other drains. A stalled receiver holds the output
// register; the queue and then the front fill up behind it, nothing is dropped.
// Reset clears all control state at once; the literal store needs no clearing.
`include "packbits_row_encoder_macros.svh"

module packbits_row_encoder #(
    parameter int MAX_RUN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbre_in_if.sink    i_in,
    pbre_out_if.source o_out
);
    import pbre_pkg::*;

    localparam int RAM_AW    = $clog2(MAX_RUN) + 1;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    logic              q_push;
    t_cmd              q_push_cmd;
    logic              q_full;
    logic              q_pop_valid;
    t_cmd              q_pop_cmd;
    logic              q_pop;
    logic              st_we;
    logic [RAM_AW-1:0] st_waddr;
    logic [7:0]        st_wdata;
    logic [RAM_AW-1:0] st_raddr;
    logic [7:0]        st_rdata;
    t_bank_rel         bank_rel;

    // front part
    pbre_front #(.MAX_RUN(MAX_RUN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd),
        .i_q_full   (q_full),
        .o_we       (st_we),
        .o_waddr    (st_waddr),
        .o_wdata    (st_wdata),
        .i_rel      (bank_rel)
    );

    // command queue
    pbre_cmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_cmd  (q_push_cmd),
        .o_full      (q_full),
        .o_pop_valid (q_pop_valid),
        .o_pop_cmd   (q_pop_cmd),
        .i_pop       (q_pop)
    );

    // literal store, two banks
    pbre_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // back part
    pbre_back #(.MAX_RUN(MAX_RUN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (q_pop_valid),
        .i_pop_cmd   (q_pop_cmd),
        .o_pop       (q_pop),
        .o_raddr     (st_raddr),
        .i_rdata     (st_rdata),
        .o_rel       (bank_rel),
        .o_out       (o_out)
    );

    // checks
    `PBRE_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, q_push, !q_full, "push into full queue")
    `PBRE_ASSERT_NEXT(a_one_byte_at_a_time, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "front took a second byte while busy")
    `PBRE_ASSERT_NOW(a_ctrl_not_last, i_clk, i_rst_n, o_out.valid && o_out.is_control, !o_out.last_of_item && !o_out.row_end, "control byte closes an item")
    `PBRE_ASSERT_NOW(a_row_end_is_last, i_clk, i_rst_n, o_out.valid && o_out.row_end, o_out.last_of_item, "row end without item end")

endmodule
